// ===== src/ndl_pkg.sv =====
// Shared constants and codes for the n-dimensional index delineariser.
package ndl_pkg;

  // Fixed field widths
  localparam int IDX_W        = 48;
  localparam int COORD_W      = 32;
  localparam int BEGIN_W      = 31;
  localparam int CFG_W        = 31;
  localparam int CFG_IDX_W    = 3;
  localparam int NUM_DIM_REGS = 3;

  // Size registers keep at most this many bits
  localparam int SIZE_CAP     = 16;

  // Quotient bits resolved per divider stage
  localparam int DIV_STEPS    = 8;

  // Parameter defaults
  localparam int MAX_DIMS_DEF  = 3;
  localparam int SIZE_BITS_DEF = 16;

  typedef enum logic [1:0] {
    ACT_FWD     = 2'd0,
    ACT_REV     = 2'd1,
    ACT_CONTAIN = 2'd2
  } act_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM_COUNT = 3'd0,
    REG_BEGIN_0   = 3'd1,
    REG_BEGIN_1   = 3'd2,
    REG_BEGIN_2   = 3'd3,
    REG_SIZE_0    = 3'd4,
    REG_SIZE_1    = 3'd5,
    REG_SIZE_2    = 3'd6
  } reg_idx_e;

endpackage

// ===== src/ndl_div_stage.sv =====
// One stage of the pipelined restoring divider: STEPS quotient bits per stage.
module ndl_div_stage #(
  parameter int DEN_W = ndl_pkg::SIZE_CAP,
  parameter int NUM_W = ndl_pkg::IDX_W,
  parameter int STEPS = ndl_pkg::DIV_STEPS
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] rem_i,
  output logic [NUM_W-1:0] num_o,
  output logic [DEN_W-1:0] rem_o
);

  logic [NUM_W-1:0] num_d, num_q;
  logic [DEN_W-1:0] rem_d, rem_q;
  logic [DEN_W:0]   part;

  // Shift dividend bits into the partial remainder, quotient bits in at the bottom
  always_comb begin
    num_d = num_i;
    rem_d = rem_i;
    part  = '0;
    for (int st = 0; st < STEPS; st++) begin
      part  = {rem_d, num_d[NUM_W-1]};
      num_d = {num_d[NUM_W-2:0], 1'b0};
      if (part >= {1'b0, den_i}) begin
        part     = part - {1'b0, den_i};
        num_d[0] = 1'b1;
      end
      rem_d = part[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign num_o = num_q;
  assign rem_o = rem_q;

endmodule

// ===== src/nd_index_delinearizer.sv =====
// Top level: linear index to coordinates over a configured extent, and range test.
//
//  channel   direction  handshake                 payload
//  in        sink       in_valid_i / in_stall_o   action, linear_index, probe_dims, probes
//  out       source     out_valid_o / out_stall_i coords, inside_res, size_error, total_size
//  cfg       sink       cfg_we_i                  cfg_index_i, cfg_data_i
//
// One beat per cycle sustained while out_stall_i is low. Beats pass an input register,
// a 48-bit division per dimension at 8 quotient bits a stage, and the output register.
// Reset clears the valid bits and loads the register reset values.
// A stalled output holds; empty stages close up so beats keep entering until every
// stage is full. Total size follows a configuration write via registered products.
module nd_index_delinearizer #(
  parameter int MAX_DIMS  = ndl_pkg::MAX_DIMS_DEF,
  parameter int SIZE_BITS = ndl_pkg::SIZE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [ndl_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ndl_pkg::CFG_W-1:0]          cfg_data_i,
  // input beats
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         action_i,
  input  logic [ndl_pkg::IDX_W-1:0]          linear_index_i,
  input  logic [1:0]                         probe_dims_i,
  input  logic signed [ndl_pkg::COORD_W-1:0] probe_coord_0_i,
  input  logic signed [ndl_pkg::COORD_W-1:0] probe_coord_1_i,
  input  logic signed [ndl_pkg::COORD_W-1:0] probe_coord_2_i,
  // result beats
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [ndl_pkg::COORD_W-1:0] coord_0_o,
  output logic signed [ndl_pkg::COORD_W-1:0] coord_1_o,
  output logic signed [ndl_pkg::COORD_W-1:0] coord_2_o,
  output logic                               inside_res_o,
  output logic                               size_error_o,
  output logic [ndl_pkg::IDX_W-1:0]          total_size_o
);

  localparam int SW  = (SIZE_BITS < ndl_pkg::SIZE_CAP) ? SIZE_BITS : ndl_pkg::SIZE_CAP;
  localparam int DPS = ndl_pkg::IDX_W / ndl_pkg::DIV_STEPS;
  localparam int NS  = MAX_DIMS * DPS;
  localparam int NST = NS + 2;
  localparam int ND  = ndl_pkg::NUM_DIM_REGS;
  localparam int CW  = ndl_pkg::COORD_W;

  // Configuration registers
  logic [1:0]                            dim_count_q;
  logic signed [ndl_pkg::BEGIN_W-1:0]    begin_q [ND];
  logic [SW-1:0]                         size_q  [ND];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_count_q <= 2'd1;
      for (int d = 0; d < ND; d++) begin
        begin_q[d] <= '0;
        size_q[d]  <= SW'(1);
      end
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ndl_pkg::REG_DIM_COUNT: dim_count_q <= cfg_data_i[1:0];
        ndl_pkg::REG_BEGIN_0:   begin_q[0]  <= cfg_data_i;
        ndl_pkg::REG_BEGIN_1:   begin_q[1]  <= cfg_data_i;
        ndl_pkg::REG_BEGIN_2:   begin_q[2]  <= cfg_data_i;
        ndl_pkg::REG_SIZE_0:    size_q[0]   <= cfg_data_i[SW-1:0];
        ndl_pkg::REG_SIZE_1:    size_q[1]   <= cfg_data_i[SW-1:0];
        ndl_pkg::REG_SIZE_2:    size_q[2]   <= cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  // Derived extent values; the user must keep them static while beats are in flight (not enforced here)
  logic [1:0]    dims;
  logic          err;
  logic [SW-1:0] size_eff [ND];

  assign dims = (dim_count_q > 2'(MAX_DIMS)) ? 2'(MAX_DIMS) : dim_count_q;

  always_comb begin
    err = 1'b0;
    for (int d = 0; d < ND; d++) begin
      if ((2'(d) < dims) && (size_q[d] == '0)) err = 1'b1;
      size_eff[d] = (2'(d) < dims) ? size_q[d] : SW'(1);
    end
  end

  // Total element count, three registered steps
  logic [2*SW-1:0]            p01_q, plo_q, phi_q;
  logic [ndl_pkg::IDX_W-1:0]  total_q;

  always_ff @(posedge clk_i) begin
    p01_q   <= (2*SW)'(size_eff[0]) * (2*SW)'(size_eff[1]);
    plo_q   <= (2*SW)'(p01_q[SW-1:0]) * (2*SW)'(size_eff[2]);
    phi_q   <= (2*SW)'(p01_q[2*SW-1:SW]) * (2*SW)'(size_eff[2]);
    total_q <= (dims == 2'd0) ? '0 :
               ndl_pkg::IDX_W'(plo_q) + (ndl_pkg::IDX_W'(phi_q) << SW);
  end

  // Range test on the incoming probe
  logic signed [CW-1:0] probe [ND];
  logic                 inside_d;
  logic signed [CW+1:0] pc, lo, hi;

  assign probe[0] = probe_coord_0_i;
  assign probe[1] = probe_coord_1_i;
  assign probe[2] = probe_coord_2_i;

  always_comb begin
    inside_d = (probe_dims_i == dims);
    pc = '0;
    lo = '0;
    hi = '0;
    for (int d = 0; d < ND; d++) begin
      pc = (CW+2)'(probe[d]);
      lo = (CW+2)'(begin_q[d]);
      hi = lo + $signed((CW+2)'(size_q[d]));
      if ((2'(d) < dims) && ((pc < lo) || (pc >= hi))) inside_d = 1'b0;
    end
  end

  // Stage enables: a stage moves when the output is not stalled or some stage at or after it is empty
  logic [NST-1:0] v_q;
  logic [NST-1:0] en;

  for (genvar s = 0; s < NST; s++) begin : g_en
    localparam logic [NST-1:0] LOW = NST'((64'(1) << s) - 64'(1));
    assign en[s] = !out_stall_i || !(&(v_q | LOW));
  end

  assign in_stall_o = !en[0];

  for (genvar s = 0; s < NST; s++) begin : g_valid
    logic vin;
    if (s == 0) begin : g_first
      assign vin = in_valid_i;
    end else begin : g_rest
      assign vin = v_q[s-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en[s]) begin
        v_q[s] <= vin;
      end
    end
  end

  // Sideband carried alongside the divider
  ndl_pkg::act_e             act_q    [NS+1];
  logic                      inside_q [NS+1];
  logic [SW-1:0]             rem_sb_q [NS+1][ND];
  logic [ndl_pkg::IDX_W-1:0] front_num_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      act_q[0]    <= ndl_pkg::act_e'(action_i);
      inside_q[0] <= inside_d;
      front_num_q <= linear_index_i;
      for (int r = 0; r < ND; r++) rem_sb_q[0][r] <= '0;
    end
  end

  function automatic logic [SW-1:0] step_size(int k, logic rev, logic [1:0] dm,
                                              logic [SW-1:0] s0, logic [SW-1:0] s1,
                                              logic [SW-1:0] s2);
    logic [1:0] sel;
    sel = rev ? 2'(dm - 2'(k) - 2'd1) : 2'(k);
    case (sel)
      2'd0:    return s0;
      2'd1:    return s1;
      default: return s2;
    endcase
  endfunction

  // Divider chain: DPS stages per dimension, remainder restarts at each dimension
  logic [ndl_pkg::IDX_W-1:0] div_num [NS];
  logic [SW-1:0]             div_rem [NS];

  for (genvar j = 0; j < NS; j++) begin : g_div
    localparam int  K     = j / DPS;
    localparam bit  FIRST = (j % DPS) == 0;
    logic [ndl_pkg::IDX_W-1:0] num_in;
    logic [SW-1:0]             rem_in;
    logic [SW-1:0]             den;

    if (j == 0) begin : g_src0
      assign num_in = front_num_q;
      assign rem_in = '0;
    end else begin : g_srcn
      assign num_in = div_num[j-1];
      assign rem_in = FIRST ? '0 : div_rem[j-1];
    end

    assign den = step_size(K, act_q[j] == ndl_pkg::ACT_REV, dims,
                           size_q[0], size_q[1], size_q[2]);

    ndl_div_stage #(
      .DEN_W (SW),
      .NUM_W (ndl_pkg::IDX_W),
      .STEPS (ndl_pkg::DIV_STEPS)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en[j+1]),
      .den_i (den),
      .num_i (num_in),
      .rem_i (rem_in),
      .num_o (div_num[j]),
      .rem_o (div_rem[j])
    );

    // Keep each finished remainder as the divider moves on to the next dimension
    always_ff @(posedge clk_i) begin
      if (en[j+1]) begin
        act_q[j+1]    <= act_q[j];
        inside_q[j+1] <= inside_q[j];
        for (int r = 0; r < ND; r++) begin
          if (FIRST && (j > 0) && (r == K - 1)) rem_sb_q[j+1][r] <= div_rem[j-1];
          else                                  rem_sb_q[j+1][r] <= rem_sb_q[j][r];
        end
      end
    end
  end

  // Remainders per step, last one straight from the divider
  logic [SW-1:0] rem_fin [ND];

  for (genvar r = 0; r < ND; r++) begin : g_fin
    if (r == MAX_DIMS - 1) begin : g_last
      assign rem_fin[r] = div_rem[NS-1];
    end else begin : g_held
      assign rem_fin[r] = rem_sb_q[NS][r];
    end
  end

  function automatic logic [CW-1:0] coord_sum(logic [SW-1:0] r,
                                              logic signed [ndl_pkg::BEGIN_W-1:0] b);
    return CW'(r) + CW'(b);
  endfunction

  // Place remainders by dimension order and add the range start
  logic [CW-1:0] coord_d [ND];

  always_comb begin
    for (int i = 0; i < ND; i++) coord_d[i] = '0;
    if (!err && (act_q[NS] == ndl_pkg::ACT_FWD)) begin
      for (int i = 0; i < ND; i++) begin
        if (2'(i) < dims) coord_d[i] = coord_sum(rem_fin[i], begin_q[i]);
      end
    end else if (!err && (act_q[NS] == ndl_pkg::ACT_REV)) begin
      case (dims)
        2'd1: begin
          coord_d[0] = coord_sum(rem_fin[0], begin_q[0]);
        end
        2'd2: begin
          coord_d[0] = coord_sum(rem_fin[1], begin_q[0]);
          coord_d[1] = coord_sum(rem_fin[0], begin_q[1]);
        end
        2'd3: begin
          coord_d[0] = coord_sum(rem_fin[2], begin_q[0]);
          coord_d[1] = coord_sum(rem_fin[1], begin_q[1]);
          coord_d[2] = coord_sum(rem_fin[0], begin_q[2]);
        end
        default: ;
      endcase
    end
  end

  // Output register
  logic [CW-1:0]  coord_q [ND];
  logic           inside_out_q;
  ndl_pkg::act_e  act_out_q;

  always_ff @(posedge clk_i) begin
    if (en[NST-1]) begin
      for (int i = 0; i < ND; i++) coord_q[i] <= coord_d[i];
      inside_out_q <= inside_q[NS] && (act_q[NS] == ndl_pkg::ACT_CONTAIN);
      act_out_q    <= act_q[NS];
    end
  end

  assign out_valid_o  = v_q[NST-1];
  assign coord_0_o    = coord_q[0];
  assign coord_1_o    = coord_q[1];
  assign coord_2_o    = coord_q[2];
  assign inside_res_o = inside_out_q;
  assign size_error_o = err;
  assign total_size_o = total_q;

  // Checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q))
    else $error("input stalled while a stage is empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && inside_res_o) |-> (act_out_q == ndl_pkg::ACT_CONTAIN))
    else $error("range hit reported for a conversion beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && size_error_o) |->
      (coord_q[0] == '0 && coord_q[1] == '0 && coord_q[2] == '0))
    else $error("coordinates not cleared on zero size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NS] && !err && dims != 2'd0 && act_q[NS] == ndl_pkg::ACT_FWD)
      |-> (rem_fin[0] < size_q[0]))
    else $error("remainder not below divisor");

endmodule
